FILE: design/mrts_pkg.sv
`default_nettype none

package mrts_pkg;

  localparam int MAX_TASKS = 8;
  localparam int NUM_TASKS = 8;
  localparam int IDX_W     = 3;
  localparam int CNT_W     = 8;
  localparam int TICK_W    = 10;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic [TICK_W-1:0] TICK_LAST = TICK_W'(999);

  // ticks per task period, task 0 first
  localparam logic [TICK_W-1:0] PERIOD [MAX_TASKS] = '{
    TICK_W'(1000), TICK_W'(500), TICK_W'(200), TICK_W'(100),
    TICK_W'(50),   TICK_W'(20),  TICK_W'(10),  TICK_W'(5)
  };

  typedef enum logic {
    ACT_TICK    = 1'b0,
    ACT_SERVICE = 1'b1
  } action_e;

  // register index taken from paddr[2]
  localparam logic REG_HANDLER_EN = 1'b0;

  typedef struct packed {
    logic [MAX_TASKS-1:0] due_mask;
    logic [MAX_TASKS-1:0] overrun_mask;
    logic [MAX_TASKS-1:0] run_mask;
    logic [MAX_TASKS-1:0] pending_mask;
    logic [CNT_W-1:0]     overrun_count;
    logic [TICK_W-1:0]    tick_position;
  } result_t;

endpackage

`default_nettype wire

FILE: design/mrts_cfg.sv
`default_nettype none

module mrts_cfg
  import mrts_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output logic [MAX_TASKS-1:0]   handler_enable_o
);

  logic [MAX_TASKS-1:0] enable_q;
  logic [MAX_TASKS-1:0] enable_d;
  logic                 wr_en;
  logic                 hit;

  assign pready = 1'b1;
  assign hit    = (paddr[2] == REG_HANDLER_EN);
  assign wr_en  = psel && penable && pwrite && pready && hit;

  always_comb begin
    enable_d = enable_q;
    if (wr_en) begin
      enable_d = pwdata[MAX_TASKS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= '0;
    end else begin
      enable_q <= enable_d;
    end
  end

  assign prdata = hit ? {{(DATA_W-MAX_TASKS){1'b0}}, enable_q} : '0;

  assign handler_enable_o = enable_q;

endmodule

`default_nettype wire

FILE: design/mrts_core.sv
`default_nettype none

module mrts_core
  import mrts_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 accept_i,
  input  wire logic                 action_i,
  input  wire logic [IDX_W-1:0]     task_index_i,
  input  wire logic [MAX_TASKS-1:0] handler_enable_i,
  output result_t                   result_o
);

  logic [TICK_W-1:0]    tick_q, tick_d;
  logic [TICK_W-1:0]    phase_q [MAX_TASKS];
  logic [TICK_W-1:0]    phase_d [MAX_TASKS];
  logic [CNT_W-1:0]     cnt_q   [MAX_TASKS];
  logic [CNT_W-1:0]     cnt_d   [MAX_TASKS];
  logic [MAX_TASKS-1:0] pend_q, pend_d;
  logic [MAX_TASKS-1:0] due, over, run;

  always_comb begin
    tick_d  = tick_q;
    pend_d  = pend_q;
    due     = '0;
    over    = '0;
    run     = '0;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    if (action_e'(action_i) == ACT_TICK) begin
      tick_d = (tick_q == TICK_LAST) ? '0 : tick_q + TICK_W'(1);
      // per-task phase counters track count mod period
      for (int i = 0; i < NUM_TASKS; i++) begin
        due[i]  = (phase_q[i] == PERIOD[i] - TICK_W'(1));
        over[i] = due[i] && pend_q[i];
        phase_d[i] = due[i] ? '0 : phase_q[i] + TICK_W'(1);
        cnt_d[i]   = cnt_q[i] + CNT_W'(over[i]);
        pend_d[i]  = pend_q[i] || due[i];
      end
    end else begin
      run    = pend_q & handler_enable_i;
      pend_d = '0;
    end
  end

  always_comb begin
    result_o.due_mask      = due;
    result_o.overrun_mask  = over;
    result_o.run_mask      = run;
    result_o.pending_mask  = pend_d;
    result_o.overrun_count = ({1'b0, task_index_i} < (IDX_W+1)'(NUM_TASKS)) ?
                             cnt_d[task_index_i] : '0;
    result_o.tick_position = tick_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
      pend_q <= '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        phase_q[i] <= '0;
        cnt_q[i]   <= '0;
      end
    end else if (accept_i) begin
      tick_q  <= tick_d;
      pend_q  <= pend_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  // the longest period equals the wrap, so its phase is the count itself
  a_phase_tracks_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q[0] == tick_q)
    else $error("task 0 phase out of step with tick count");

  a_tick_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_q <= TICK_LAST)
    else $error("tick count beyond wrap");

  a_service_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && (action_e'(action_i) == ACT_SERVICE) |=> pend_q == '0)
    else $error("pending flags survive service");

  a_overrun_only_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (over & ~due) == '0)
    else $error("overrun without due");

endmodule

`default_nettype wire

FILE: design/mrts_outbuf.sv
`default_nettype none

module mrts_outbuf
  import mrts_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire result_t result_i,
  output logic         stall_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output result_t      result_o
);

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    out_ready;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign stall_o   = skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_ready) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = result_i;
        out_valid_d = push_i;
      end
    end else if (push_i) begin
      skid_d       = result_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a result while output is empty");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && out_valid_q && out_stall_i |=> skid_valid_q)
    else $error("transfer lost while output stalled");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && !out_stall_i |=> !skid_valid_q && out_valid_q)
    else $error("skid not drained");

endmodule

`default_nettype wire

FILE: design/multirate_tick_flag_scheduler_unit.sv
`default_nettype none

// Multi-rate tick scheduler: each input transfer is a tick (action 0) or a
// service request (action 1) and yields exactly one result transfer. Eight
// tasks with periods of 1000, 500, 200, 100, 50, 20, 10 and 5 ticks are
// tracked by per-task phase counters; a tick sets the pending flag of every
// due task and bumps its 8-bit overrun counter if it was already pending.
// A service request clears all pending flags and returns the pending tasks
// with a handler enabled as run_mask. One item per cycle while in_stall_o
// is low: the whole update is a single registered pass, followed by a
// two-entry output buffer, so in_stall_o rises only after the output has
// been stalled with a result waiting behind it. The handler enable register
// sits at APB byte address 0; the user must write it only while the block
// is idle, and the block itself does not enforce this.
module multirate_tick_flag_scheduler_unit
  import mrts_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_W-1:0]    paddr,
  input  wire logic [DATA_W-1:0]    pwdata,
  output logic      [DATA_W-1:0]    prdata,
  output logic                      pready,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 action_i,
  input  wire logic [IDX_W-1:0]     task_index_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [MAX_TASKS-1:0]      due_mask_o,
  output logic [MAX_TASKS-1:0]      overrun_mask_o,
  output logic [MAX_TASKS-1:0]      run_mask_o,
  output logic [MAX_TASKS-1:0]      pending_mask_o,
  output logic [CNT_W-1:0]          overrun_count_o,
  output logic [TICK_W-1:0]         tick_position_o
);

  logic [MAX_TASKS-1:0] handler_enable;
  logic                 accept;
  logic                 buf_stall;
  result_t              core_result;
  result_t              out_result;

  assign accept     = in_valid_i && !buf_stall;
  assign in_stall_o = buf_stall;

  mrts_cfg u_cfg (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .handler_enable_o (handler_enable)
  );

  mrts_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .action_i         (action_i),
    .task_index_i     (task_index_i),
    .handler_enable_i (handler_enable),
    .result_o         (core_result)
  );

  mrts_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .result_i    (core_result),
    .stall_o     (buf_stall),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_result)
  );

  assign due_mask_o      = out_result.due_mask;
  assign overrun_mask_o  = out_result.overrun_mask;
  assign run_mask_o      = out_result.run_mask;
  assign pending_mask_o  = out_result.pending_mask;
  assign overrun_count_o = out_result.overrun_count;
  assign tick_position_o = out_result.tick_position;

endmodule

`default_nettype wire
